[rtl/rqg_pkg.sv]
// Shared types, constants and a rounding helper for the 3x3 Givens RQ unit.
package rqg_pkg;

    localparam int FIELD_W       = 32;
    localparam int ENT_W         = 33;
    localparam int WORD_BITS_DEF = 32;
    localparam int NROWS         = 6;
    localparam int RAD_W         = 64;
    localparam int ROOT_STEPS    = 32;
    localparam int DIV_STEPS     = 31;
    localparam int NORM_STEPS    = 5;

    typedef logic signed [ENT_W-1:0] t_ent;
    // rows 0..2 hold A (becoming R), rows 3..5 the rotated identity (Q transposed)
    typedef t_ent t_mat [NROWS][3];
    typedef logic [1:0] t_col;

    typedef struct packed {
        logic skip;
        logic sx;
        logic st;
    } t_side;

    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] low;
        logic [30:0] quo;
    } t_div;

    localparam t_ent ONE_Q30     = 33'sd1073741824;
    localparam t_ent NEG_ONE_Q30 = -33'sd1073741824;

    localparam logic signed [63:0] LIM64     = 64'sd4294967295;
    localparam logic signed [63:0] RND_POS   = 64'sd536870912;
    localparam logic signed [63:0] RND_NEG   = 64'sd536870911;

    // rotation order: target row, target column, pivot column
    localparam t_col ROT_ROW [3] = '{2'd2, 2'd2, 2'd1};
    localparam t_col ROT_P   [3] = '{2'd1, 2'd0, 2'd0};
    localparam t_col ROT_Q   [3] = '{2'd2, 2'd2, 2'd1};

    // Q.30 product back to an entry, half away from zero, held to +-(2^32-1)
    function automatic t_ent rnd_q30(input logic signed [63:0] v);
        logic signed [63:0] w;
        w = (v + (v[63] ? RND_NEG : RND_POS)) >>> 30;
        if (w > LIM64) begin
            w = LIM64;
        end else if (w < -LIM64) begin
            w = -LIM64;
        end
        return w[ENT_W-1:0];
    endfunction

endpackage

[rtl/rqg_if.sv]
// Valid/ready channel interfaces for matrix beats in and row beats out.
interface rqg_in_if import rqg_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] a_00;
    logic signed [FIELD_W-1:0] a_01;
    logic signed [FIELD_W-1:0] a_02;
    logic signed [FIELD_W-1:0] a_10;
    logic signed [FIELD_W-1:0] a_11;
    logic signed [FIELD_W-1:0] a_12;
    logic signed [FIELD_W-1:0] a_20;
    logic signed [FIELD_W-1:0] a_21;
    logic signed [FIELD_W-1:0] a_22;

    modport source (output valid, a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22,
                    input ready);
    modport sink   (input valid, a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22,
                    output ready);
endinterface

interface rqg_out_if import rqg_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                row_index;
    logic signed [FIELD_W-1:0] r_col0;
    logic signed [FIELD_W-1:0] r_col1;
    logic signed [FIELD_W-1:0] r_col2;
    logic signed [FIELD_W-1:0] q_col0;
    logic signed [FIELD_W-1:0] q_col1;
    logic signed [FIELD_W-1:0] q_col2;
    logic                      last_row;

    modport source (output valid, row_index, r_col0, r_col1, r_col2,
                    q_col0, q_col1, q_col2, last_row, input ready);
    modport sink   (input valid, row_index, r_col0, r_col1, r_col2,
                    q_col0, q_col1, q_col2, last_row, output ready);
endinterface

[rtl/rq_decomposition_3x3_givens_unit.sv]
// RQ factorisation of a 3x3 Q16.16 matrix by three Givens rotations: top level.
//
// Input channel i_in: one beat carries a whole matrix a_00..a_22. Output channel
// o_out: three beats per matrix, rows 0, 1, 2 in order, each with a row of R
// (saturated to the word range) and a row of Q in Q1.30; last_row marks row 2.
// Each rotation is a 76-stage chain of cells (normalise, square, sum, 32 root
// cells, numerator, 31 divider cells, cosine/sine, multiply, add, round); a
// matrix that leaves the last rotation is loaded into the row buffer once the
// buffer is free, row 0 is then offered, and rows 1 and 2 follow on the next
// cycles when the receiver keeps ready high. The chain takes a beat in every
// cycle until it fills; sustained throughput is then set by the three output
// beats per matrix.
// While the receiver stalls, the chain keeps advancing into empty stages and
// only freezes once a finished matrix waits behind the row buffer; ready then
// drops. Reset empties the chain and the row buffer; nothing is kept across
// matrices and there is no configuration.
module rq_decomposition_3x3_givens_unit import rqg_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rqg_in_if.sink       i_in,
    rqg_out_if.source    o_out
);

    localparam int   EFF_BITS  = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;
    localparam t_ent R_HI      = (33'sd1 <<< (EFF_BITS - 1)) - 33'sd1;
    localparam t_ent R_LO      = -R_HI - 33'sd1;
    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST  = 2'd2;

    logic [FIELD_W-1:0] w_a [3][3];
    t_mat               w_src;
    t_mat               w_mat [4];
    logic [3:0]         w_vld;
    logic               w_en;
    logic               w_take;

    logic               r_busy;
    logic [1:0]         r_row;
    logic [FIELD_W-1:0] r_r [3][3];
    logic [FIELD_W-1:0] r_q [3][3];

    function automatic logic [FIELD_W-1:0] sat_r(input t_ent v);
        t_ent w;
        w = (v > R_HI) ? R_HI : ((v < R_LO) ? R_LO : v);
        return w[FIELD_W-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] clamp_q(input t_ent v);
        t_ent w;
        w = (v > ONE_Q30) ? ONE_Q30 : ((v < NEG_ONE_Q30) ? NEG_ONE_Q30 : v);
        return w[FIELD_W-1:0];
    endfunction

    assign w_a[0][0] = i_in.a_00;
    assign w_a[0][1] = i_in.a_01;
    assign w_a[0][2] = i_in.a_02;
    assign w_a[1][0] = i_in.a_10;
    assign w_a[1][1] = i_in.a_11;
    assign w_a[1][2] = i_in.a_12;
    assign w_a[2][0] = i_in.a_20;
    assign w_a[2][1] = i_in.a_21;
    assign w_a[2][2] = i_in.a_22;

    // bits above the word width are ignored; rows 3..5 start as the identity
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_src[i][j]   = t_ent'($signed(w_a[i][j][EFF_BITS-1:0]));
                w_src[3+i][j] = (i == j) ? ONE_Q30 : '0;
            end
        end
    end

    assign w_mat[0]   = w_src;
    assign w_vld[0]   = i_in.valid;
    assign w_take     = w_vld[3] && (!r_busy || (r_row == ROW_LAST && o_out.ready));
    assign w_en       = !w_vld[3] || w_take;
    assign i_in.ready = w_en;

    for (genvar k = 0; k < 3; k++) begin : g_rot
        rqg_givens #(
            .STEP(k)
        ) u_rot (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_vld  (w_vld[k]),
            .i_mat  (w_mat[k]),
            .o_vld  (w_vld[k+1]),
            .o_mat  (w_mat[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= ROW_FIRST;
        end else if (w_take) begin
            r_busy <= 1'b1;
            r_row  <= ROW_FIRST;
        end else if (r_busy && o_out.ready) begin
            if (r_row == ROW_LAST) begin
                r_busy <= 1'b0;
            end else begin
                r_row <= r_row + 2'd1;
            end
        end
    end

    // row buffer: Q rows are the columns of the rotated identity
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_r[k][j] <= sat_r(w_mat[3][k][j]);
                    r_q[k][j] <= clamp_q(w_mat[3][3+j][k]);
                end
            end
        end
    end

    assign o_out.valid     = r_busy;
    assign o_out.row_index = r_row;
    assign o_out.r_col0    = r_r[r_row][0];
    assign o_out.r_col1    = r_r[r_row][1];
    assign o_out.r_col2    = r_r[r_row][2];
    assign o_out.q_col0    = r_q[r_row][0];
    assign o_out.q_col1    = r_q[r_row][1];
    assign o_out.q_col2    = r_q[r_row][2];
    assign o_out.last_row  = (r_row == ROW_LAST);

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && r_row != ROW_LAST)
        |=> (o_out.valid && r_row == $past(r_row) + 2'd1))
        else $error("row beats out of order");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.row_index != 2'd3))
        else $error("row index out of range");

    a_tail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[3] && !w_en) |=> (w_vld[3] && $stable(w_mat[3][0][0])))
        else $error("finished matrix lost while stalled");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !o_out.ready) |=> (r_busy && $stable(r_row)))
        else $error("row beat dropped under stall");

endmodule

[rtl/rqg_root_cell.sv]
// One restoring step of the integer square root, one result bit per cell.
module rqg_root_cell import rqg_pkg::*; #(
    parameter int unsigned BIT_POS = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [RAD_W-1:0] i_rem,
    input  logic [RAD_W-1:0] i_root,
    output logic [RAD_W-1:0] o_rem,
    output logic [RAD_W-1:0] o_root
);

    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * BIT_POS);

    logic [RAD_W-1:0] w_trial;
    logic [RAD_W-1:0] n_rem;
    logic [RAD_W-1:0] n_root;

    always_comb begin
        w_trial = i_root + BIT;
        if (i_rem >= w_trial) begin
            n_rem  = i_rem - w_trial;
            n_root = (i_root >> 1) + BIT;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_root <= n_root;
        end
    end

endmodule

[rtl/rqg_div_cell.sv]
// One restoring division step for the cosine and sine quotients over a shared divisor.
module rqg_div_cell import rqg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_d,
    input  t_div [1:0]  i_lane,
    output logic [31:0] o_d,
    output t_div [1:0]  o_lane
);

    t_div [1:0]  n_lane;
    logic [32:0] w_part [2];
    logic [32:0] w_diff [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_part[l] = {i_lane[l].rem, i_lane[l].low[30]};
            w_diff[l] = w_part[l] - {1'b0, i_d};
            n_lane[l].low = {i_lane[l].low[29:0], 1'b0};
            if (w_part[l] >= {1'b0, i_d}) begin
                n_lane[l].rem = w_diff[l][31:0];
                n_lane[l].quo = {i_lane[l].quo[29:0], 1'b1};
            end else begin
                n_lane[l].rem = w_part[l][31:0];
                n_lane[l].quo = {i_lane[l].quo[29:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d    <= i_d;
            o_lane <= n_lane;
        end
    end

endmodule

[rtl/rqg_givens.sv]
// One Givens column rotation as a pipeline of cells: normalise, root, divide, rotate.
module rqg_givens import rqg_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_vld,
    input  t_mat i_mat,
    output logic o_vld,
    output t_mat o_mat
);

    localparam int ROW   = int'(ROT_ROW[STEP]);
    localparam int COL_P = int'(ROT_P[STEP]);
    localparam int COL_Q = int'(ROT_Q[STEP]);

    localparam int ST_SQR   = NORM_STEPS + 1;
    localparam int ST_SUM   = ST_SQR + 1;
    localparam int ST_ROOT0 = ST_SUM + 1;
    localparam int ST_NUM   = ST_ROOT0 + ROOT_STEPS;
    localparam int ST_DIV0  = ST_NUM + 1;
    localparam int ST_CS    = ST_DIV0 + DIV_STEPS;
    localparam int ST_MUL   = ST_CS + 1;
    localparam int ST_ADD   = ST_MUL + 1;
    localparam int ST_RND   = ST_ADD + 1;
    localparam int N_ST     = ST_RND + 1;

    logic [N_ST-1:0] r_vld;
    t_mat            r_mat  [N_ST];
    t_side           r_side [N_ST];

    logic [30:0] r_xn [ST_NUM];
    logic [30:0] r_tn [ST_NUM];
    logic [30:0] r_mx [NORM_STEPS+1];
    logic [61:0] r_xx;
    logic [61:0] r_tt;
    logic [RAD_W-1:0] r_v;
    t_div [1:0]  r_lane0;
    logic [31:0] r_d0;
    logic signed [31:0] r_c;
    logic signed [31:0] r_s;
    logic signed [63:0] r_pac [NROWS];
    logic signed [63:0] r_pbs [NROWS];
    logic signed [63:0] r_pbc [NROWS];
    logic signed [63:0] r_pas [NROWS];
    logic signed [63:0] r_np  [NROWS];
    logic signed [63:0] r_nq  [NROWS];

    logic [RAD_W-1:0] w_rem  [ROOT_STEPS+1];
    logic [RAD_W-1:0] w_root [ROOT_STEPS+1];
    t_div [1:0]       w_lane [DIV_STEPS+1];
    logic [31:0]      w_d    [DIV_STEPS+1];

    t_ent        w_x0;
    t_ent        w_t0;
    logic [31:0] w_xa0;
    logic [31:0] w_ta0;
    logic [31:0] w_mm0;
    logic [30:0] n_xn0;
    logic [30:0] n_tn0;
    logic [30:0] n_mx0;
    t_side       n_side0;
    logic [61:0] w_nx;
    logic [61:0] w_nt;
    logic [31:0] w_den;
    t_div [1:0]  n_lane0;
    logic [31:0] w_cm;
    logic [31:0] w_sm;
    t_mat        n_rot;

    // entry stage: magnitudes, then one right shift if the larger reaches 2^31
    always_comb begin
        w_x0  = i_mat[ROW][COL_Q];
        w_t0  = i_mat[ROW][COL_P];
        w_xa0 = w_x0[ENT_W-1] ? 32'(-w_x0) : 32'(w_x0);
        w_ta0 = w_t0[ENT_W-1] ? 32'(-w_t0) : 32'(w_t0);
        w_mm0 = (w_xa0 > w_ta0) ? w_xa0 : w_ta0;
        if (w_mm0[31]) begin
            n_xn0 = w_xa0[31:1];
            n_tn0 = w_ta0[31:1];
            n_mx0 = w_mm0[31:1];
        end else begin
            n_xn0 = w_xa0[30:0];
            n_tn0 = w_ta0[30:0];
            n_mx0 = w_mm0[30:0];
        end
        n_side0.skip = (w_t0 == '0);
        n_side0.sx   = w_x0[ENT_W-1];
        n_side0.st   = w_t0[ENT_W-1];
    end

    // numerators (m << 30) + d/2 for the two quotients
    always_comb begin
        w_den = w_root[ROOT_STEPS][31:0];
        w_nx = (62'(r_xn[ST_NUM-1]) << 30) + 62'(w_den >> 1);
        w_nt = (62'(r_tn[ST_NUM-1]) << 30) + 62'(w_den >> 1);
        n_lane0[0].rem = 32'(w_nx[61:31]);
        n_lane0[0].low = w_nx[30:0];
        n_lane0[0].quo = '0;
        n_lane0[1].rem = 32'(w_nt[61:31]);
        n_lane0[1].low = w_nt[30:0];
        n_lane0[1].quo = '0;
        w_cm = {1'b0, w_lane[DIV_STEPS][0].quo};
        w_sm = {1'b0, w_lane[DIV_STEPS][1].quo};
    end

    always_comb begin
        n_rot = r_mat[ST_RND-1];
        if (!r_side[ST_RND-1].skip) begin
            for (int rr = 0; rr < NROWS; rr++) begin
                n_rot[rr][COL_P] = rnd_q30(r_np[rr]);
                n_rot[rr][COL_Q] = rnd_q30(r_nq[rr]);
            end
            n_rot[ROW][COL_P] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N_ST-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mat[0]  <= i_mat;
            r_side[0] <= n_side0;
            for (int i = 1; i < N_ST - 1; i++) begin
                r_mat[i] <= r_mat[i-1];
            end
            for (int i = 1; i < N_ST; i++) begin
                r_side[i] <= r_side[i-1];
            end
            r_mat[N_ST-1] <= n_rot;

            r_xn[0] <= n_xn0;
            r_tn[0] <= n_tn0;
            r_mx[0] <= n_mx0;
            // left shifts by 16, 8, 4, 2, 1 bring the larger into [2^30, 2^31)
            for (int g = 1; g <= NORM_STEPS; g++) begin
                if (r_mx[g-1] < (31'd1 << (31 - (1 << (NORM_STEPS - g))))) begin
                    r_xn[g] <= r_xn[g-1] << (1 << (NORM_STEPS - g));
                    r_tn[g] <= r_tn[g-1] << (1 << (NORM_STEPS - g));
                    r_mx[g] <= r_mx[g-1] << (1 << (NORM_STEPS - g));
                end else begin
                    r_xn[g] <= r_xn[g-1];
                    r_tn[g] <= r_tn[g-1];
                    r_mx[g] <= r_mx[g-1];
                end
            end
            for (int i = ST_SQR; i < ST_NUM; i++) begin
                r_xn[i] <= r_xn[i-1];
                r_tn[i] <= r_tn[i-1];
            end

            r_xx <= 62'(r_xn[NORM_STEPS]) * 62'(r_xn[NORM_STEPS]);
            r_tt <= 62'(r_tn[NORM_STEPS]) * 62'(r_tn[NORM_STEPS]);
            r_v  <= RAD_W'(r_xx) + RAD_W'(r_tt);

            r_d0    <= w_den;
            r_lane0 <= n_lane0;

            r_c <= r_side[ST_CS-1].sx ? -$signed(w_cm) : $signed(w_cm);
            r_s <= r_side[ST_CS-1].st ? $signed(w_sm) : -$signed(w_sm);

            for (int rr = 0; rr < NROWS; rr++) begin
                r_pac[rr] <= r_mat[ST_MUL-1][rr][COL_P] * r_c;
                r_pbs[rr] <= r_mat[ST_MUL-1][rr][COL_Q] * r_s;
                r_pbc[rr] <= r_mat[ST_MUL-1][rr][COL_Q] * r_c;
                r_pas[rr] <= r_mat[ST_MUL-1][rr][COL_P] * r_s;
                r_np[rr]  <= r_pac[rr] + r_pbs[rr];
                r_nq[rr]  <= r_pbc[rr] - r_pas[rr];
            end
        end
    end

    assign w_rem[0]  = r_v;
    assign w_root[0] = '0;

    for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
        rqg_root_cell #(
            .BIT_POS(ROOT_STEPS - 1 - g)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_rem (w_rem[g]),
            .i_root(w_root[g]),
            .o_rem (w_rem[g+1]),
            .o_root(w_root[g+1])
        );
    end

    assign w_lane[0] = r_lane0;
    assign w_d[0]    = r_d0;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        rqg_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (w_d[g]),
            .i_lane(w_lane[g]),
            .o_d   (w_d[g+1]),
            .o_lane(w_lane[g+1])
        );
    end

    assign o_vld = r_vld[N_ST-1];
    assign o_mat = r_mat[N_ST-1];

endmodule

[test/rq_decomposition_3x3_givens_unit_test.sv]
// Self-checking bench for the 3x3 Givens RQ unit: directed and random matrices.
module rq_decomposition_3x3_givens_unit_test;
    import rqg_pkg::*;

    typedef logic signed [31:0] t_word;
    typedef struct packed {
        logic [1:0] row;
        t_word      r0, r1, r2, q0, q1, q2;
        logic       last;
    } t_row_beat;
    typedef struct {
        t_word a [3][3];
        logic  chk;
        t_word r [3][3];
    } t_stim;

    localparam int RAND_MATS = 450;
    localparam int IDLE_LIMIT = 20000;
    localparam longint LIM = 64'd4294967295;
    localparam longint ONE30 = 64'd1073741824;

    logic i_clk;
    logic i_rst_n;
    rqg_in_if  in_ch ();
    rqg_out_if out_ch ();

    rq_decomposition_3x3_givens_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_row_beat rows_due [$];
    t_word     r_due [$];
    logic      r_due_chk [$];
    int        n_fail = 0;
    int        n_mats = 0;
    int        n_rows = 0;
    int        idle_cycles = 0;
    bit        sending_done = 0;
    bit        hold_off = 0;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch row %0d %s: got %0d want %0d", n_rows, what, got, want);
        n_fail++;
    endtask

    function automatic longint iabs(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint round30(input longint v);
        longint m;
        m = (iabs(v) + (64'd1 << 29)) >>> 30;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint root64(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic rotation_pair(input longint x, input longint t,
                                 output longint c, output longint s);
        longint unsigned xa, ta, m, d;
        xa = iabs(x);
        ta = iabs(t);
        m = xa > ta ? xa : ta;
        while (m >= (64'd1 << 31)) begin
            m >>= 1; xa >>= 1; ta >>= 1;
        end
        while (m < (64'd1 << 30)) begin
            m <<= 1; xa <<= 1; ta <<= 1;
        end
        d = root64(xa * xa + ta * ta);
        c = ((xa << 30) + (d >> 1)) / d;
        s = ((ta << 30) + (d >> 1)) / d;
        if (x < 0) c = -c;
        if (t >= 0) s = -s;
    endtask

    // Columns p,q of both the working matrix (rows 0..2) and identity (3..5)
    task automatic predict_rq(input t_word a [3][3]);
        longint w [6][3];
        longint c, s, u, v;
        int rr [3] = '{2, 2, 1};
        int pp [3] = '{1, 0, 0};
        int qq [3] = '{2, 2, 1};
        t_row_beat b;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                w[i][j] = a[i][j];
                w[i + 3][j] = (i == j) ? ONE30 : 0;
            end
        for (int k = 0; k < 3; k++) begin
            if (w[rr[k]][pp[k]] == 0) continue;
            rotation_pair(w[rr[k]][qq[k]], w[rr[k]][pp[k]], c, s);
            for (int i = 0; i < 6; i++) begin
                u = w[i][pp[k]];
                v = w[i][qq[k]];
                w[i][pp[k]] = clamp(round30(u * c + v * s), -LIM, LIM);
                w[i][qq[k]] = clamp(round30(v * c - u * s), -LIM, LIM);
            end
            w[rr[k]][pp[k]] = 0;
        end
        for (int k = 0; k < 3; k++) begin
            b.row = k[1:0];
            b.r0 = clamp(w[k][0], -64'd2147483648, 64'd2147483647);
            b.r1 = clamp(w[k][1], -64'd2147483648, 64'd2147483647);
            b.r2 = clamp(w[k][2], -64'd2147483648, 64'd2147483647);
            b.q0 = clamp(w[3][k], -ONE30, ONE30);
            b.q1 = clamp(w[4][k], -ONE30, ONE30);
            b.q2 = clamp(w[5][k], -ONE30, ONE30);
            b.last = (k == 2);
            rows_due.push_back(b);
        end
    endtask

    function automatic t_word rnd_entry();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            3: return t_word'($urandom_range(0, 255)) - 128;
            default: return t_word'($signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000);
        endcase
    endfunction

    task automatic send(input t_stim st);
        in_ch.a_00 <= st.a[0][0]; in_ch.a_01 <= st.a[0][1]; in_ch.a_02 <= st.a[0][2];
        in_ch.a_10 <= st.a[1][0]; in_ch.a_11 <= st.a[1][1]; in_ch.a_12 <= st.a[1][2];
        in_ch.a_20 <= st.a[2][0]; in_ch.a_21 <= st.a[2][1]; in_ch.a_22 <= st.a[2][2];
        in_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_rq(st.a);
        // diagonal of R typed in for rows where it is obvious
        for (int k = 0; k < 3; k++) begin
            r_due.push_back(st.r[k][k]);
            r_due_chk.push_back(st.chk);
        end
        n_mats++;
        @(negedge i_clk);
        if ($urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 3))
                @(negedge i_clk);
        end
    endtask

    function automatic t_stim diag_row(input t_word d0, d1, d2, input logic chk);
        t_stim st;
        foreach (st.a[i, j]) begin
            st.a[i][j] = 0;
            st.r[i][j] = 0;
        end
        st.a[0][0] = d0; st.a[1][1] = d1; st.a[2][2] = d2;
        st.r[0][0] = d0; st.r[1][1] = d1; st.r[2][2] = d2;
        st.chk = chk;
        return st;
    endfunction

    // stimulus: directed table (with six random matrices at its end) first, then random matrices
    initial begin
        t_stim table_rows [$];
        t_stim st;
        t_word ext [4] = '{32'sh7fffffff, 32'sh80000000, 32'sh1, 32'shffffffff};
        i_rst_n = 0;
        in_ch.valid = 0;
        {in_ch.a_00, in_ch.a_01, in_ch.a_02, in_ch.a_10, in_ch.a_11, in_ch.a_12,
         in_ch.a_20, in_ch.a_21, in_ch.a_22} = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // zero targets skip every rotation: R is the input, Q the identity
        table_rows.push_back(diag_row(0, 0, 0, 1));
        table_rows.push_back(diag_row(32'sh10000, 32'sh10000, 32'sh10000, 1));
        table_rows.push_back(diag_row(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1));
        table_rows.push_back(diag_row(32'sh80000000, 32'sh1, 32'shffffffff, 1));
        // zero pivots with nonzero targets
        st = diag_row(0, 0, 0, 0); st.a[2][1] = 32'sh10000; table_rows.push_back(st);
        st = diag_row(0, 0, 0, 0); st.a[2][0] = -32'sh10000; table_rows.push_back(st);
        st = diag_row(0, 0, 0, 0); st.a[1][0] = 32'sh80000000; table_rows.push_back(st);
        // all-extreme matrices drive the working range into saturation
        for (int e = 0; e < 4; e++) begin
            st = diag_row(0, 0, 0, 0);
            foreach (st.a[i, j]) st.a[i][j] = ext[(e + i + j) % 4];
            table_rows.push_back(st);
        end
        for (int e = 0; e < 4; e++) begin
            st = diag_row(0, 0, 0, 0);
            foreach (st.a[i, j]) st.a[i][j] = ext[e];
            table_rows.push_back(st);
        end
        for (int n = 0; n < 6; n++) begin
            st = diag_row(0, 0, 0, 0);
            foreach (st.a[i, j]) st.a[i][j] = rnd_entry();
            table_rows.push_back(st);
        end
        foreach (table_rows[n]) send(table_rows[n]);

        for (int n = 0; n < RAND_MATS; n++) begin
            st = diag_row(0, 0, 0, 0);
            foreach (st.a[i, j]) st.a[i][j] = rnd_entry();
            if (n == 100) hold_off = 1;
            send(st);
        end
        in_ch.valid <= 1'b0;
        sending_done = 1;
    end

    // receiver: random stalls, plus one long hold-off to back the chain up
    initial begin
        out_ch.ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                out_ch.ready <= 1'b0;
                repeat (600) @(negedge i_clk);
                hold_off = 0;
                out_ch.ready <= 1'b1;
            end else if ($urandom_range(0, 49) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(5, 60)) @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end else if ((n_rows / 200) % 2 == 1) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        t_row_beat w;
        logic chk;
        t_word rd;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (rows_due.size() == 0) begin
                report("unexpected beat", out_ch.row_index, -1);
            end else begin
                w = rows_due.pop_front();
                rd = r_due.pop_front();
                chk = r_due_chk.pop_front();
                if (out_ch.row_index !== w.row) report("row_index", out_ch.row_index, w.row);
                if (out_ch.r_col0 !== w.r0) report("r_col0", out_ch.r_col0, w.r0);
                if (out_ch.r_col1 !== w.r1) report("r_col1", out_ch.r_col1, w.r1);
                if (out_ch.r_col2 !== w.r2) report("r_col2", out_ch.r_col2, w.r2);
                if (out_ch.q_col0 !== w.q0) report("q_col0", out_ch.q_col0, w.q0);
                if (out_ch.q_col1 !== w.q1) report("q_col1", out_ch.q_col1, w.q1);
                if (out_ch.q_col2 !== w.q2) report("q_col2", out_ch.q_col2, w.q2);
                if (out_ch.last_row !== w.last) report("last_row", out_ch.last_row, w.last);
                if (chk) begin
                    case (w.row)
                        2'd0: if (out_ch.r_col0 !== rd) report("R diagonal", out_ch.r_col0, rd);
                        2'd1: if (out_ch.r_col1 !== rd) report("R diagonal", out_ch.r_col1, rd);
                        default:
                            if (out_ch.r_col2 !== rd) report("R diagonal", out_ch.r_col2, rd);
                    endcase
                    if (out_ch.q_col0 !== (w.row == 0 ? ONE30 : 0))
                        report("Q identity", out_ch.q_col0, w.row == 0 ? ONE30 : 0);
                end
            end
            n_rows++;
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        @(posedge i_rst_n);
        while (!(sending_done && rows_due.size() == 0) && idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d rows outstanding", rows_due.size());
            $display("Regression FAIL");
        end else begin
            repeat (300) @(posedge i_clk);
            $display("covered %0d matrices (%0d row beats) incl. zero/extreme/saturating",
                     n_mats, n_rows);
            $display("random stalls on both channels and one long receiver hold-off");
            if (n_fail == 0)
                $display("Regression PASS");
            else
                $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/rqg_pkg.sv
rtl/rqg_if.sv
rtl/rqg_root_cell.sv
rtl/rqg_div_cell.sv
rtl/rqg_givens.sv
rtl/rq_decomposition_3x3_givens_unit.sv
test/rq_decomposition_3x3_givens_unit_test.sv
